// File: rtl/core/bba_pkg.sv
// Shared types, codes and default sizes of the buddy block allocator.
package bba_pkg;

  localparam int POOL_ORDER_DEF   = 16;
  localparam int MIN_ORDER_DEF    = 5;
  localparam int HEADER_BYTES_DEF = 24;

  localparam int SIZE_W  = 20;
  localparam int ADDR_W  = 16;
  localparam int ORDER_W = 5;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_BAD_REQ  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

endpackage

// File: rtl/core/bba_if.sv
// Request and response channel interfaces of the buddy block allocator.
interface bba_req_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [SIZE_W-1:0]   request_size;
  logic [ADDR_W-1:0]   block_address;

  modport source (output valid, action, request_size, block_address, input ready);
  modport sink   (input valid, action, request_size, block_address, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [ADDR_W-1:0]   data_offset;
  logic [ORDER_W-1:0]  block_order;

  modport source (output valid, status, data_offset, block_order, input ready);
  modport sink   (input valid, status, data_offset, block_order, output ready);
endinterface

// File: rtl/core/buddy_block_allocator_top.sv
// Buddy block allocator: request decode, tree walk sequencer and node/unit memories.
//
// The block serves a pool of 2^POOL_ORDER bytes. Each word on the req channel is
// either an allocate (action 0, request_size bytes) or a free (action 1,
// block_address as returned by an earlier allocate). Each request produces
// exactly one word on the rsp channel with a status, an offset and an order.
//
// The free tree lives in a node memory: each node keeps a mask of the block
// orders that are free somewhere in its subtree. An allocate reads the root,
// descends toward the lowest free block of the smallest sufficient order,
// writes the split halves, and then climbs back to the root rewriting masks.
// A free reads the unit memory, merges upward while buddies are free, and
// climbs the same way. The descent walks S_ADESC level by level and each split
// is an S_ASPLIT step, while every merge step passes through S_FMRG and S_FBUD
// and every climb step through S_CLW and S_CLR. Errors go from S_DEC, S_AROOT
// or S_FUNIT straight to S_RESULT.
//
// One request is handled at a time; req.ready is high only when the sequencer
// is idle, which it becomes in the cycle after the previous result is loaded. The
// response sits in an output register; if the receiver stalls, the next
// request may still be taken and its result waits until the register is free.
// After reset a clearing pass writes both memories; no request is taken while
// it runs.
module buddy_block_allocator_top #(
  parameter int POOL_ORDER   = bba_pkg::POOL_ORDER_DEF,
  parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
  parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  bba_req_if.sink  req,
  bba_rsp_if.source rsp
);
  import bba_pkg::*;

  // Node index width (tree of 2^NW slots), unit index width, mask width.
  localparam int NW = POOL_ORDER - MIN_ORDER + 1;
  localparam int UW = POOL_ORDER - MIN_ORDER;
  localparam int MW = NW;
  localparam int AW = POOL_ORDER;
  localparam int UDW = ORDER_W + 1;
  localparam int NEED_W = SIZE_W + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC, S_AROOT, S_ADESC, S_ASPLIT,
    S_FUNIT, S_FMRG, S_FBUD, S_CLW, S_CLR, S_RESULT
  } state_t;

  // Byte offset of the block that node n at order o stands for.
  function automatic logic [AW-1:0] node_addr(input logic [NW-1:0] n,
                                              input logic [ORDER_W-1:0] o);
    logic [NW-1:0] idx;
    idx = n & ~(NW'(1) << (POOL_ORDER - int'(o)));
    return AW'(idx) << o;
  endfunction

  function automatic logic [UW-1:0] unit_of_node(input logic [NW-1:0] n,
                                                 input logic [ORDER_W-1:0] o);
    return UW'(node_addr(n, o) >> MIN_ORDER);
  endfunction

  function automatic logic [NW-1:0] node_of_unit(input logic [UW-1:0] u,
                                                 input logic [ORDER_W-1:0] o);
    return (NW'(1) << (POOL_ORDER - int'(o))) | NW'(u >> (int'(o) - MIN_ORDER));
  endfunction

  function automatic logic [MW-1:0] mbit(input logic [ORDER_W-1:0] o);
    return MW'(1) << (int'(o) - MIN_ORDER);
  endfunction

  state_t               state;
  logic [NW-1:0]        idx;
  logic                 act;
  logic [SIZE_W-1:0]    size;
  logic [ADDR_W-1:0]    daddr;
  logic [ORDER_W-1:0]   k;
  logic [ORDER_W-1:0]   j;
  logic [ORDER_W-1:0]   m;
  logic [NW-1:0]        n;
  logic [MW-1:0]        cur;
  status_t              res_status;
  logic [ADDR_W-1:0]    res_off;
  logic [ORDER_W-1:0]   res_order;

  // Memories.
  logic [MW-1:0]  nmem [2**NW];
  logic [UDW-1:0] umem [2**UW];
  logic [MW-1:0]  nrd;
  logic [UDW-1:0] urd;
  logic           nwe, uwe;
  logic [NW-1:0]  nwa, nra;
  logic [MW-1:0]  nwd;
  logic [UW-1:0]  uwa, ura;
  logic [UDW-1:0] uwd;

  always_ff @(posedge clk) begin
    if (nwe) begin
      nmem[nwa] <= nwd;
    end
    if (uwe) begin
      umem[uwa] <= uwd;
    end
    nrd <= nmem[nra];
    urd <= umem[ura];
  end

  // Allocate decode: order is the bit length of size + header - 1.
  logic [NEED_W-1:0]  need, tneed;
  logic [ORDER_W-1:0] kraw, k_eff;
  logic               a_bad;
  always_comb begin
    need  = NEED_W'(size) + NEED_W'(HEADER_BYTES);
    tneed = need - NEED_W'(1);
    kraw  = '0;
    for (int i = 0; i < NEED_W; i++) begin
      if (tneed[i]) begin
        kraw = ORDER_W'(i + 1);
      end
    end
    k_eff = (kraw < ORDER_W'(MIN_ORDER)) ? ORDER_W'(MIN_ORDER) : kraw;
    a_bad = (size == '0) || (k_eff > ORDER_W'(POOL_ORDER));
  end

  // Free decode.
  logic [ADDR_W-1:0] off;
  logic              f_bad;
  logic [UW-1:0]     f_u;
  always_comb begin
    off   = daddr - ADDR_W'(HEADER_BYTES);
    f_bad = (daddr < ADDR_W'(HEADER_BYTES)) || (off[MIN_ORDER-1:0] != '0) ||
            ((32'(off) >> POOL_ORDER) != 32'd0);
    f_u   = UW'(32'(off) >> MIN_ORDER);
  end

  // Smallest free order at or above k, taken from the root mask.
  logic [MW-1:0]      masked;
  logic [ORDER_W-1:0] jsel;
  logic               found;
  always_comb begin
    masked = nrd & ({MW{1'b1}} << (int'(k) - MIN_ORDER));
    found  = |masked;
    jsel   = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (masked[i]) begin
        jsel = ORDER_W'(i + MIN_ORDER);
      end
    end
  end

  logic               left_has;
  logic [NW-1:0]      n_next;
  logic               bud_free;
  logic [NW-1:0]      sib_up;
  logic [ORDER_W-1:0] ord_in, k0;
  always_comb begin
    left_has = |(nrd & mbit(j));
    n_next   = {n[NW-2:0], ~left_has};
    bud_free = |(nrd & mbit(m));
    sib_up   = {n[NW-2:0], 1'b1};
    ord_in   = urd[UDW-1:1];
    if (ord_in < ORDER_W'(MIN_ORDER)) begin
      k0 = ORDER_W'(MIN_ORDER);
    end else if (ord_in > ORDER_W'(POOL_ORDER)) begin
      k0 = ORDER_W'(POOL_ORDER);
    end else begin
      k0 = ord_in;
    end
  end

  // Memory control.
  always_comb begin
    nwe = 1'b0;
    nwa = n;
    nwd = '0;
    nra = NW'(1);
    uwe = 1'b0;
    uwa = f_u;
    uwd = '0;
    ura = f_u;
    case (state)
      S_INIT: begin
        nwe = 1'b1;
        nwa = idx;
        nwd = (idx == NW'(1)) ? mbit(ORDER_W'(POOL_ORDER)) : '0;
        uwe = ~idx[NW-1];
        uwa = idx[UW-1:0];
        uwd = (idx == '0) ? {ORDER_W'(POOL_ORDER), 1'b0} : '0;
      end
      S_DEC: begin
        nra = NW'(1);
        ura = f_u;
      end
      S_AROOT: nra = NW'(2);
      S_ADESC: nra = {n_next[NW-2:0], 1'b0};
      S_ASPLIT: begin
        uwe = 1'b1;
        if (m > k) begin
          nwe = 1'b1;
          nwa = sib_up;
          nwd = mbit(m - ORDER_W'(1));
          uwa = unit_of_node(sib_up, m - ORDER_W'(1));
          uwd = {m - ORDER_W'(1), 1'b0};
        end else begin
          uwa = unit_of_node(n, k);
          uwd = {k, 1'b1};
        end
      end
      S_FUNIT: begin
        uwe = urd[0];
        uwa = f_u;
        uwd = {ord_in, 1'b0};
      end
      S_FMRG: begin
        nwe = 1'b1;
        nwa = n;
        nwd = '0;
        nra = n ^ NW'(1);
        uwe = (m == ORDER_W'(POOL_ORDER));
        uwa = unit_of_node(n, m);
        uwd = {m, 1'b0};
      end
      S_FBUD: begin
        nwe = bud_free;
        nwa = n ^ NW'(1);
        nwd = '0;
        uwe = ~bud_free;
        uwa = unit_of_node(n, m);
        uwd = {m, 1'b0};
      end
      S_CLW: begin
        nwe = 1'b1;
        nwa = n;
        nwd = cur;
        nra = n ^ NW'(1);
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);

  logic out_load;
  assign out_load = (state == S_RESULT) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp.valid       <= 1'b1;
        rsp.status      <= res_status;
        rsp.data_offset <= res_off;
        rsp.block_order <= res_order;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          idx <= idx + NW'(1);
          if (idx == {NW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            act   <= req.action;
            size  <= req.request_size;
            daddr <= req.block_address;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          res_off   <= '0;
          res_order <= '0;
          if (act == ACT_ALLOC) begin
            if (a_bad) begin
              res_status <= ST_BAD_REQ;
              state      <= S_RESULT;
            end else begin
              k     <= k_eff;
              state <= S_AROOT;
            end
          end else if (f_bad) begin
            res_status <= ST_BAD_FREE;
            state      <= S_RESULT;
          end else begin
            state <= S_FUNIT;
          end
        end
        S_AROOT: begin
          if (!found) begin
            res_status <= ST_NO_MEM;
            state      <= S_RESULT;
          end else begin
            j     <= jsel;
            n     <= NW'(1);
            m     <= ORDER_W'(POOL_ORDER);
            state <= (jsel == ORDER_W'(POOL_ORDER)) ? S_ASPLIT : S_ADESC;
          end
        end
        S_ADESC: begin
          n <= n_next;
          m <= m - ORDER_W'(1);
          if (m - ORDER_W'(1) == j) begin
            state <= S_ASPLIT;
          end
        end
        S_ASPLIT: begin
          if (m > k) begin
            n <= {n[NW-2:0], 1'b0};
            m <= m - ORDER_W'(1);
          end else begin
            cur        <= '0;
            res_status <= ST_OK;
            res_off    <= ADDR_W'(node_addr(n, k)) + ADDR_W'(HEADER_BYTES);
            res_order  <= k;
            state      <= S_CLW;
          end
        end
        S_FUNIT: begin
          if (!urd[0]) begin
            res_status <= ST_BAD_FREE;
            state      <= S_RESULT;
          end else begin
            n     <= node_of_unit(f_u, k0);
            m     <= k0;
            state <= S_FMRG;
          end
        end
        S_FMRG: begin
          if (m == ORDER_W'(POOL_ORDER)) begin
            cur        <= mbit(m);
            res_status <= ST_OK;
            res_off    <= ADDR_W'(node_addr(n, m));
            res_order  <= m;
            state      <= S_CLW;
          end else begin
            state <= S_FBUD;
          end
        end
        S_FBUD: begin
          if (bud_free) begin
            n     <= n >> 1;
            m     <= m + ORDER_W'(1);
            state <= S_FMRG;
          end else begin
            cur        <= mbit(m);
            res_status <= ST_OK;
            res_off    <= ADDR_W'(node_addr(n, m));
            res_order  <= m;
            state      <= S_CLW;
          end
        end
        S_CLW: begin
          state <= (m == ORDER_W'(POOL_ORDER)) ? S_RESULT : S_CLR;
        end
        S_CLR: begin
          cur   <= cur | nrd;
          n     <= n >> 1;
          m     <= m + ORDER_W'(1);
          state <= S_CLW;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // No request is taken while the clearing pass runs.
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !req.ready)
    else $error("request accepted during clearing pass");

  // Outside the clearing pass the unused node slot zero is never written.
  a_node_zero: assert property (@(posedge clk) disable iff (rst)
    (nwe && state != S_INIT) |-> nwa != '0)
    else $error("write to unused node slot");

  // A new response word only appears after the result state.
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_RESULT)
    else $error("response without result state");

  // A successful result always carries an order within the pool.
  a_ok_order: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_OK) |->
      (rsp.block_order >= ORDER_W'(MIN_ORDER) && rsp.block_order <= ORDER_W'(POOL_ORDER)))
    else $error("ok result with order out of range");

endmodule

// File: verif/bba_tb_if.sv
// Testbench-side note: the channel interfaces come from the RTL file bba_if.sv.
// This file holds the watchdog and drain constants shared by the bench.
package bba_tb_pkg;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  // Quiet cycles after the last result before the end-of-run check.
  localparam int DRAIN_CYCLES = 200;
endpackage

// File: verif/tb.sv
// Top-level testbench of the buddy block allocator: predictor, scoreboard and drivers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;
  import bba_tb_pkg::*;

  localparam int POOL_ORDER   = POOL_ORDER_DEF;
  localparam int MIN_ORDER    = MIN_ORDER_DEF;
  localparam int HEADER_BYTES = HEADER_BYTES_DEF;
  localparam int UNITS        = 1 << (POOL_ORDER - MIN_ORDER);
  localparam int NODES        = 2 * UNITS;

  // One response word as the block should produce it.
  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   data_offset;
    logic [ORDER_W-1:0]  block_order;
  } alloc_result_t;

  // Scoreboard: keeps a copy of the allocator's free tree and per-unit tables,
  // predicts each response when a request word is accepted, and compares the
  // actual response words against the queue of predictions in order.
  class alloc_scoreboard;
    bit                 node_free[NODES];
    bit [ORDER_W-1:0]   unit_ord[UNITS];
    bit                 unit_rsv[UNITS];
    alloc_result_t      pending[$];
    int                 errors;
    // Offsets of blocks currently held, so the stimulus can free them.
    int                 held[$];

    function new();
      for (int i = 0; i < NODES; i++) node_free[i] = 0;
      for (int i = 0; i < UNITS; i++) begin
        unit_ord[i] = '0;
        unit_rsv[i] = 0;
      end
      node_free[1] = 1;
      unit_ord[0]  = ORDER_W'(POOL_ORDER);
      errors = 0;
    endfunction

    function int node_idx(int addr, int k);
      return (1 << (POOL_ORDER - k)) + (addr >> k);
    endfunction

    function alloc_result_t grant(logic [SIZE_W-1:0] size);
      alloc_result_t r;
      longint need;
      int k, j, addr, base, upper;
      bit found;
      r = '{ST_OK, '0, '0};
      k = 0;
      found = 0;
      addr = 0;
      if (size == 0) begin
        r.status = ST_BAD_REQ;
        return r;
      end
      need = longint'(size) + HEADER_BYTES - 1;
      while (need != 0) begin
        need = need >> 1;
        k++;
      end
      if (k < MIN_ORDER) k = MIN_ORDER;
      if (k > POOL_ORDER) begin
        r.status = ST_BAD_REQ;
        return r;
      end
      for (j = k; j <= POOL_ORDER; j++) begin
        base = 1 << (POOL_ORDER - j);
        for (int i = 0; i < base; i++) begin
          if (node_free[base + i]) begin
            addr = i << j;
            found = 1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) begin
        r.status = ST_NO_MEM;
        return r;
      end
      node_free[node_idx(addr, j)] = 0;
      while (j > k) begin
        j--;
        upper = addr + (1 << j);
        node_free[node_idx(upper, j)] = 1;
        unit_ord[upper >> MIN_ORDER] = ORDER_W'(j);
        unit_rsv[upper >> MIN_ORDER] = 0;
      end
      unit_ord[addr >> MIN_ORDER] = ORDER_W'(k);
      unit_rsv[addr >> MIN_ORDER] = 1;
      r.data_offset = ADDR_W'(addr + HEADER_BYTES);
      r.block_order = ORDER_W'(k);
      held.push_back(addr + HEADER_BYTES);
      return r;
    endfunction

    function alloc_result_t release_block(logic [ADDR_W-1:0] daddr);
      alloc_result_t r;
      int off, addr, k, u, buddy, bn;
      r = '{ST_BAD_FREE, '0, '0};
      if (daddr < HEADER_BYTES) return r;
      off = daddr - HEADER_BYTES;
      if ((off & ((1 << MIN_ORDER) - 1)) != 0) return r;
      if (off >= (1 << POOL_ORDER)) return r;
      addr = off;
      u = addr >> MIN_ORDER;
      if (!unit_rsv[u]) return r;
      unit_rsv[u] = 0;
      k = unit_ord[u];
      if (k < MIN_ORDER) k = MIN_ORDER;
      if (k > POOL_ORDER) k = POOL_ORDER;
      while (k < POOL_ORDER) begin
        buddy = addr ^ (1 << k);
        bn = node_idx(buddy, k);
        if (!node_free[bn]) break;
        node_free[bn] = 0;
        if (buddy < addr) addr = buddy;
        k++;
      end
      unit_ord[addr >> MIN_ORDER] = ORDER_W'(k);
      node_free[node_idx(addr, k)] = 1;
      for (int i = 0; i < held.size(); i++) begin
        if (held[i] == int'(daddr)) begin
          held.delete(i);
          break;
        end
      end
      r.status = ST_OK;
      r.data_offset = ADDR_W'(addr);
      r.block_order = ORDER_W'(k);
      return r;
    endfunction

    // Called for every accepted request word.
    function void note_request(logic act, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] daddr);
      if (act == ACT_ALLOC) pending.push_back(grant(size));
      else pending.push_back(release_block(daddr));
    endfunction

    // Called for every accepted response word.
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: response with nothing expected: status %s offset %0d order %0d",
                 $realtime, got.status.name(), got.data_offset, got.block_order);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %s actual %s", $realtime,
                 want.status.name(), got.status.name());
        errors++;
      end
      if (got.data_offset !== want.data_offset) begin
        $display("%0t: data_offset expected %0d actual %0d", $realtime,
                 want.data_offset, got.data_offset);
        errors++;
      end
      if (got.block_order !== want.block_order) begin
        $display("%0t: block_order expected %0d actual %0d", $realtime,
                 want.block_order, got.block_order);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  bba_req_if req ();
  bba_rsp_if rsp ();

  buddy_block_allocator_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  alloc_scoreboard sb = new();

  // When set, both sides stop idling so the tail of the run is back to back.
  bit  no_idle = 0;
  int  quiet_cycles = 0;
  int  allocs_done = 0;
  int  frees_done = 0;

  // Sample both channels at the rising edge; this is the only place where the
  // scoreboard learns what was accepted, so ordering within a step cannot
  // matter. The watchdog counts edges with no accepted word.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        sb.note_request(req.action, req.request_size, req.block_address);
        if (req.action == ACT_ALLOC) allocs_done++;
        else frees_done++;
      end
      if (rsp.valid && rsp.ready)
        sb.check_result('{rsp.status, rsp.data_offset, rsp.block_order});
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, sb.pending.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: ready drops in random bursts, with runs of steady readiness in
  // between. Changes happen on the falling edge.
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Present one request word and hold it until the block takes it.
  task automatic send_word(logic act, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] daddr);
    req.valid         <= 1'b1;
    req.action        <= act;
    req.request_size  <= size;
    req.block_address <= daddr;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    // Sender gaps: random bursts, never in the closing part of the run.
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic send_alloc(logic [SIZE_W-1:0] size);
    send_word(ACT_ALLOC, size, ADDR_W'($urandom));
  endtask

  task automatic send_free(logic [ADDR_W-1:0] daddr);
    send_word(ACT_FREE, SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)), daddr);
  endtask

  // Hold the sender off until every predicted response has been seen.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Sizes mostly small so the pool holds many blocks at once, with an
  // occasional large one to exercise deep splits and out-of-memory.
  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return SIZE_W'($urandom_range(1, 200));
    if (sel < 17) return SIZE_W'($urandom_range(1, 4000));
    if (sel < 19) return SIZE_W'($urandom_range(1, (1 << POOL_ORDER) - HEADER_BYTES));
    return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
  endfunction

  // A free address: mostly a block that is held, otherwise noise, a stale
  // address or one off by a few bytes.
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sb.held.size() != 0 && sel < 8)
      return ADDR_W'(sb.held[$urandom_range(0, sb.held.size() - 1)]);
    if (sel == 8) return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    return ADDR_W'(HEADER_BYTES + ($urandom_range(0, UNITS - 1) << MIN_ORDER)
                   + $urandom_range(0, 2));
  endfunction

  initial begin
    int n_items;
    int burst;
    logic [ADDR_W-1:0] a;
    req.valid         = 1'b0;
    req.action        = ACT_ALLOC;
    req.request_size  = '0;
    req.block_address = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero size, smallest and largest fitting sizes, oversize,
    // the all-ones size, a full pool, out of memory, and the bad frees.
    send_alloc('0);
    send_alloc(SIZE_W'(1));
    send_alloc(SIZE_W'((1 << MIN_ORDER) - HEADER_BYTES));
    send_alloc(SIZE_W'((1 << MIN_ORDER) - HEADER_BYTES + 1));
    send_alloc('1);
    send_alloc(SIZE_W'((1 << POOL_ORDER) - HEADER_BYTES + 1));
    send_free('0);
    send_free(ADDR_W'(HEADER_BYTES - 1));
    send_free(ADDR_W'(HEADER_BYTES + 1));
    send_free('1);
    send_free(ADDR_W'(HEADER_BYTES + (1 << MIN_ORDER) * 5));
    wait_drained();
    // Release everything so the whole pool merges back, then take it whole.
    while (sb.held.size() != 0) send_free(ADDR_W'(sb.held[0]));
    send_free(ADDR_W'(HEADER_BYTES));
    send_alloc(SIZE_W'((1 << POOL_ORDER) - HEADER_BYTES));
    send_alloc(SIZE_W'(1));
    send_free(ADDR_W'(HEADER_BYTES));
    send_free(ADDR_W'(HEADER_BYTES));
    wait_drained();

    // Random part: bursts leaning toward allocation, then toward release,
    // so the pool fills to exhaustion and empties again repeatedly.
    n_items = 0;
    while (n_items < 1400) begin
      if (n_items > 1250) no_idle = 1;
      burst = $urandom_range(10, 60);
      for (int i = 0; i < burst; i++) begin
        if ((n_items / 100) % 2 == 0 ? $urandom_range(0, 9) < 7
                                     : $urandom_range(0, 9) < 3)
          send_alloc(pick_size());
        else begin
          a = pick_free_addr();
          send_free(a);
        end
        n_items++;
      end
      if (!no_idle && $urandom_range(0, 7) == 0) wait_drained();
    end

    // Drain, then give the sequencer room to finish before the final verdict.
    req.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d allocates and %0d frees, including full pool, exhaustion",
             allocs_done, frees_done);
    $display("and every error status; %0d blocks still held at the end.", sb.held.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
